@@ rtl/core/c2dszp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package c2dszp_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int MAX_KERNEL = 7;

   localparam int IMG_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int KER_DEPTH = MAX_KERNEL * MAX_KERNEL;
   localparam int IMG_AW    = $clog2(IMG_DEPTH);
   localparam int KER_AW    = $clog2(KER_DEPTH);

   localparam int OP_W     = 2;
   localparam int POS_W    = 6;
   localparam int DATA_W   = 16;
   localparam int PROD_W   = 2 * DATA_W;
   localparam int ACC_W    = 38;
   localparam int OUT_W    = 32;
   localparam int STATUS_W = 2;
   localparam int DIM_W    = 7;
   localparam int KDIM_W   = 3;
   localparam int COORD_W  = 8;
   localparam int SHIFT    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   localparam logic [OP_W-1:0] OP_KERNEL_WR = 2'd0;
   localparam logic [OP_W-1:0] OP_PIXEL_WR  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_KERNEL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_POS    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;

   typedef struct packed {
      logic write;
      logic start;
      logic issue;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic start_err;
      logic tap_last;
      logic pipe_empty;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/core/c2dszp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module c2dszp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/c2dszp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module c2dszp_ctrl
   import c2dszp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [OP_W-1:0]  req_opcode,
   output logic                  req_stall,
   input  wire dp_status_type    dp_sts,
   output ctrl_cmd_type          cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ISSUE = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.write  = accept;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_opcode == OP_COMPUTE)) begin
               cmd.start = 1'b1;
               state_in  = dp_sts.start_err ? S_DONE : S_ISSUE;
            end
         end
         S_ISSUE: begin
            cmd.issue = 1'b1;
            if (dp_sts.tap_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (dp_sts.pipe_empty) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (dp_sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/c2dszp_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module c2dszp_dp
   import c2dszp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctrl_cmd_type            cmd,
   output dp_status_type                dp_sts,
   input  wire logic [OP_W-1:0]         req_opcode,
   input  wire logic [POS_W-1:0]        req_row,
   input  wire logic [POS_W-1:0]        req_col,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic                    csr_valid,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [POS_W-1:0]             rsp_out_row,
   output logic [POS_W-1:0]             rsp_out_col,
   output logic signed [OUT_W-1:0]      rsp_out_value,
   output logic [STATUS_W-1:0]          rsp_status
);

   logic [DIM_W-1:0]  iw_ff, ih_ff;
   logic [KDIM_W-1:0] kw_ff, kh_ff;
   logic [DIM_W-1:0]  w_eff, h_eff;
   logic [KDIM_W-1:0] hw, hh;
   logic              kdim_bad, pos_bad;
   logic [STATUS_W-1:0] start_status;

   logic [POS_W-1:0]    row_ff, col_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [KDIM_W-1:0]   i_ff, j_ff;
   logic [KDIM_W-1:0]   i_in, j_in;

   logic signed [COORD_W-1:0] tap_r, tap_c;
   logic                      tap_inside;
   logic [IMG_AW-1:0]         img_rd_addr;
   logic [KER_AW-1:0]         ker_rd_addr;

   logic img_wr_en, ker_wr_en;
   logic [IMG_AW-1:0] img_wr_addr;
   logic [KER_AW-1:0] ker_wr_addr;
   logic signed [DATA_W-1:0] img_rd_data, ker_rd_data;
   logic signed [DATA_W-1:0] pixel;

   logic                     p1_valid_ff, p1_inside_ff;
   logic                     p2_valid_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_shift;

   logic                     rsp_valid_ff;
   logic [POS_W-1:0]         rsp_row_ff, rsp_col_ff;
   logic signed [OUT_W-1:0]  rsp_value_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;

   // Store writes
   assign ker_wr_en   = cmd.write && (req_opcode == OP_KERNEL_WR)
                        && (int'(req_row) < MAX_KERNEL) && (int'(req_col) < MAX_KERNEL);
   assign img_wr_en   = cmd.write && (req_opcode == OP_PIXEL_WR)
                        && (int'(req_row) < MAX_HEIGHT) && (int'(req_col) < MAX_WIDTH);
   assign ker_wr_addr = KER_AW'(int'(req_row) * MAX_KERNEL + int'(req_col));
   assign img_wr_addr = IMG_AW'(int'(req_row) * MAX_WIDTH + int'(req_col));

   // Request checks
   assign w_eff    = (int'(iw_ff) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : iw_ff;
   assign h_eff    = (int'(ih_ff) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : ih_ff;
   assign kdim_bad = !kw_ff[0] || !kh_ff[0]
                     || (int'(kw_ff) > MAX_KERNEL) || (int'(kh_ff) > MAX_KERNEL);
   assign pos_bad  = ({1'b0, req_row} >= h_eff) || ({1'b0, req_col} >= w_eff);

   always_comb begin
      if (kdim_bad) begin
         start_status = ST_BAD_KERNEL;
      end else if (pos_bad) begin
         start_status = ST_BAD_POS;
      end else begin
         start_status = ST_OK;
      end
   end

   // Tap address generation
   assign hw    = (kw_ff - KDIM_W'(1)) >> 1;
   assign hh    = (kh_ff - KDIM_W'(1)) >> 1;
   assign tap_r = $signed({2'b00, row_ff}) + $signed({5'b00000, hh})
                  - $signed({5'b00000, i_ff});
   assign tap_c = $signed({2'b00, col_ff}) + $signed({5'b00000, hw})
                  - $signed({5'b00000, j_ff});
   assign tap_inside  = (tap_r >= 0) && (tap_c >= 0)
                        && (tap_r < $signed({1'b0, h_eff}))
                        && (tap_c < $signed({1'b0, w_eff}));
   assign img_rd_addr = IMG_AW'(int'(tap_r[POS_W-1:0]) * MAX_WIDTH
                                + int'(tap_c[POS_W-1:0]));
   assign ker_rd_addr = KER_AW'(int'(i_ff) * MAX_KERNEL + int'(j_ff));

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      if (cmd.start) begin
         i_in = '0;
         j_in = '0;
      end else if (cmd.issue) begin
         if (j_ff == kw_ff - KDIM_W'(1)) begin
            j_in = '0;
            i_in = i_ff + KDIM_W'(1);
         end else begin
            j_in = j_ff + KDIM_W'(1);
         end
      end
   end

   c2dszp_ram #(.WIDTH(DATA_W), .DEPTH(IMG_DEPTH)) u_img_ram (
      .clock   (clock),
      .wr_en   (img_wr_en),
      .wr_addr (img_wr_addr),
      .wr_data (req_value),
      .rd_en   (cmd.issue),
      .rd_addr (img_rd_addr),
      .rd_data (img_rd_data)
   );

   c2dszp_ram #(.WIDTH(DATA_W), .DEPTH(KER_DEPTH)) u_ker_ram (
      .clock   (clock),
      .wr_en   (ker_wr_en),
      .wr_addr (ker_wr_addr),
      .wr_data (req_value),
      .rd_en   (cmd.issue),
      .rd_addr (ker_rd_addr),
      .rd_data (ker_rd_data)
   );

   assign pixel     = p1_inside_ff ? img_rd_data : '0;
   assign acc_shift = acc_ff >>> SHIFT;

   assign dp_sts.start_err  = (start_status != ST_OK);
   assign dp_sts.tap_last   = (i_ff == kh_ff - KDIM_W'(1)) && (j_ff == kw_ff - KDIM_W'(1));
   assign dp_sts.pipe_empty = !p1_valid_ff && !p2_valid_ff;
   assign dp_sts.out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff        <= DIM_W'(MAX_WIDTH);
         ih_ff        <= DIM_W'(MAX_HEIGHT);
         kw_ff        <= KDIM_W'(3);
         kh_ff        <= KDIM_W'(3);
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_IMAGE_WIDTH:   iw_ff <= csr_wdata;
               REG_IMAGE_HEIGHT:  ih_ff <= csr_wdata;
               REG_KERNEL_WIDTH:  kw_ff <= csr_wdata[KDIM_W-1:0];
               REG_KERNEL_HEIGHT: kh_ff <= csr_wdata[KDIM_W-1:0];
               default: ;
            endcase
         end
         p1_valid_ff <= cmd.issue;
         p2_valid_ff <= p1_valid_ff;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      p1_inside_ff <= tap_inside;
      prod_ff      <= pixel * ker_rd_data;
      if (cmd.start) begin
         row_ff    <= req_row;
         col_ff    <= req_col;
         status_ff <= start_status;
         acc_ff    <= '0;
      end else if (p2_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.finish) begin
         rsp_row_ff    <= row_ff;
         rsp_col_ff    <= col_ff;
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= acc_shift[OUT_W-1:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

`default_nettype wire

@@ rtl/core/conv2d_same_zero_pad_unit.sv @@
// Kernel and pixel write items may follow back to back.
// A compute item does one multiply-accumulate per kernel tap through the store read ports,
// and no new item is taken until its result has gone into the output register; an item
// with a bad kernel size or position skips the taps and goes straight to the result.
// Synchronous reset sets the size registers to 64x64 image and 3x3 kernel; stores are unset.
`timescale 1ns / 1ps
`default_nettype none

module conv2d_same_zero_pad_unit
   import c2dszp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [OP_W-1:0]          req_opcode,
   input  wire logic [POS_W-1:0]         req_row,
   input  wire logic [POS_W-1:0]         req_col,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [POS_W-1:0]              rsp_out_row,
   output logic [POS_W-1:0]              rsp_out_col,
   output logic signed [OUT_W-1:0]       rsp_out_value,
   output logic [STATUS_W-1:0]           rsp_status,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_sts;

   assign csr_ready = 1'b1;

   c2dszp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .dp_sts     (dp_sts),
      .cmd        (cmd)
   );

   c2dszp_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .dp_sts        (dp_sts),
      .req_opcode    (req_opcode),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .csr_valid     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_status    (rsp_status)
   );

endmodule

`default_nettype wire

@@ dv/conv2d_same_zero_pad_unit_test.sv @@
`timescale 1ns / 1ps

module conv2d_same_zero_pad_unit_test;
   import c2dszp_pkg::*;

   localparam logic [OP_W-1:0]      OP_UNUSED     = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LO = 3'd4;
   localparam int SETTLE_CYCLES = MAX_KERNEL * MAX_KERNEL + 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_LIMIT    = 5000;
   localparam int MAX_GAP       = 12;
   localparam int PHASE_ITEMS   = 135;

   typedef struct {
      logic [POS_W-1:0]        row;
      logic [POS_W-1:0]        col;
      logic signed [OUT_W-1:0] value;
      logic [STATUS_W-1:0]     status;
   } conv_result_type;

   typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_type;

   class conv_scoreboard;
      logic signed [DATA_W-1:0] pixels [IMG_DEPTH];
      logic signed [DATA_W-1:0] coeffs [KER_DEPTH];
      logic [DIM_W-1:0]  img_w;
      logic [DIM_W-1:0]  img_h;
      logic [KDIM_W-1:0] ker_w;
      logic [KDIM_W-1:0] ker_h;
      conv_result_type pending_pixels [$];
      int failures;

      function new();
         foreach (pixels[i]) pixels[i] = '0;
         foreach (coeffs[i]) coeffs[i] = '0;
         img_w = 7'd64;
         img_h = 7'd64;
         ker_w = 3'd3;
         ker_h = 3'd3;
         failures = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_IMAGE_WIDTH:   img_w = data[DIM_W-1:0];
            REG_IMAGE_HEIGHT:  img_h = data[DIM_W-1:0];
            REG_KERNEL_WIDTH:  ker_w = data[KDIM_W-1:0];
            REG_KERNEL_HEIGHT: ker_h = data[KDIM_W-1:0];
            default: ;
         endcase
      endfunction

      function bit dim_bad(logic [KDIM_W-1:0] d);
         return d[0] == 1'b0 || int'(d) > MAX_KERNEL;
      endfunction

      function conv_result_type convolve(logic [POS_W-1:0] row, logic [POS_W-1:0] col);
         conv_result_type res;
         int w, h, hh, hw, r, c, k, l;
         longint acc;
         w = (int'(img_w) < MAX_WIDTH) ? int'(img_w) : MAX_WIDTH;
         h = (int'(img_h) < MAX_HEIGHT) ? int'(img_h) : MAX_HEIGHT;
         res.row = row;
         res.col = col;
         res.value = '0;
         res.status = ST_OK;
         if (dim_bad(ker_w) || dim_bad(ker_h)) begin
            res.status = ST_BAD_KERNEL;
         end else if (int'(row) >= h || int'(col) >= w) begin
            res.status = ST_BAD_POS;
         end else begin
            hh = (int'(ker_h) - 1) / 2;
            hw = (int'(ker_w) - 1) / 2;
            acc = 0;
            for (k = -hh; k <= hh; k++) begin
               for (l = -hw; l <= hw; l++) begin
                  r = int'(row) + k;
                  c = int'(col) + l;
                  if (r >= 0 && c >= 0 && r < h && c < w) begin
                     acc += longint'(pixels[r * MAX_WIDTH + c])
                          * longint'(coeffs[(hh - k) * MAX_KERNEL + (hw - l)]);
                  end
               end
            end
            res.value = OUT_W'(acc >>> SHIFT);
         end
         return res;
      endfunction

      function void note_input(logic [OP_W-1:0] op, logic [POS_W-1:0] row,
                               logic [POS_W-1:0] col, logic signed [DATA_W-1:0] val);
         case (op)
            OP_KERNEL_WR: begin
               if (int'(row) < MAX_KERNEL && int'(col) < MAX_KERNEL)
                  coeffs[int'(row) * MAX_KERNEL + int'(col)] = val;
            end
            OP_PIXEL_WR: begin
               if (int'(row) < MAX_HEIGHT && int'(col) < MAX_WIDTH)
                  pixels[int'(row) * MAX_WIDTH + int'(col)] = val;
            end
            OP_COMPUTE: pending_pixels.push_back(convolve(row, col));
            default: ;
         endcase
      endfunction

      function void check_result(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                 logic signed [OUT_W-1:0] value, logic [STATUS_W-1:0] status);
         conv_result_type want;
         if (pending_pixels.size() == 0) begin
            $error("result item at row %0d col %0d with no compute waiting", row, col);
            failures++;
            return;
         end
         want = pending_pixels.pop_front();
         if (row !== want.row) begin
            $error("out_row expected %0d actual %0d", want.row, row);
            failures++;
         end
         if (col !== want.col) begin
            $error("out_col expected %0d actual %0d", want.col, col);
            failures++;
         end
         if (value !== want.value) begin
            $error("out_value expected %0d actual %0d", want.value, value);
            failures++;
         end
         if (status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, status);
            failures++;
         end
      endfunction

      function int pending();
         return pending_pixels.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [OP_W-1:0]          req_opcode = OP_KERNEL_WR;
   logic [POS_W-1:0]         req_row = '0;
   logic [POS_W-1:0]         req_col = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [POS_W-1:0]         rsp_out_row;
   logic [POS_W-1:0]         rsp_out_col;
   logic signed [OUT_W-1:0]  rsp_out_value;
   logic [STATUS_W-1:0]      rsp_status;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = REG_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   conv2d_same_zero_pad_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_status    (rsp_status),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #10 clock = ~clock;

   conv_scoreboard sb;
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_out_row, rsp_out_col, rsp_out_value, rsp_status);
         if (req_valid && !req_stall)
            sb.note_input(req_opcode, req_row, req_col, req_value);
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_wdata);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL conv2d_same_zero_pad_unit");
            $finish;
         end
      end
   end

   rx_mode_type rx_mode = RX_FREE;
   int rx_span = 0;
   int rx_period = 2;
   int rx_on = 1;
   int rx_phase = 0;
   int hold_left = 0;
   int hold_requests = 0;
   int holds_done = 0;
   logic stall_next;

   always @(posedge clock) begin
      if (rx_span == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_span = $urandom_range(20, 300);
         rx_period = $urandom_range(2, 9);
         rx_on = $urandom_range(1, rx_period - 1);
      end
      rx_span--;
      rx_phase = (rx_phase + 1) % rx_period;
      if (hold_left > 0) begin
         hold_left--;
         stall_next = 1'b1;
      end else if (hold_requests != holds_done) begin
         holds_done++;
         hold_left = HOLD_CYCLES - 1;
         stall_next = 1'b1;
      end else begin
         case (rx_mode)
            RX_FREE:  stall_next = 1'b0;
            RX_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
            RX_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
            default:  stall_next = (rx_phase < rx_on);
         endcase
      end
      rsp_stall <= stall_next;
   end

   bit px_written [IMG_DEPTH];
   bit cf_written [KER_DEPTH];
   int eff_w = MAX_WIDTH;
   int eff_h = MAX_HEIGHT;
   int span_w = 3;
   int span_h = 3;
   int burst_left = 0;
   int item_count = 0;

   function automatic logic signed [DATA_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] row,
                            logic [POS_W-1:0] col, logic signed [DATA_W-1:0] val);
      item_count++;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_row <= row;
      req_col <= col;
      req_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pace();
   endtask

   task automatic send_pixel(int row, int col, logic signed [DATA_W-1:0] val);
      px_written[row * MAX_WIDTH + col] = 1'b1;
      send_item(OP_PIXEL_WR, POS_W'(row), POS_W'(col), val);
   endtask

   task automatic send_coeff(int row, int col, logic signed [DATA_W-1:0] val);
      if (row < MAX_KERNEL && col < MAX_KERNEL)
         cf_written[row * MAX_KERNEL + col] = 1'b1;
      send_item(OP_KERNEL_WR, POS_W'(row), POS_W'(col), val);
   endtask

   // Unset coefficients and in-image window pixels go first if valid.
   task automatic send_compute(int row, int col);
      int hh, hw, r, c, i, j;
      if (span_w % 2 == 1 && span_h % 2 == 1 && row < eff_h && col < eff_w) begin
         for (i = 0; i < span_h; i++)
            for (j = 0; j < span_w; j++)
               if (!cf_written[i * MAX_KERNEL + j]) send_coeff(i, j, pick_sample());
         hh = (span_h - 1) / 2;
         hw = (span_w - 1) / 2;
         for (r = row - hh; r <= row + hh; r++)
            for (c = col - hw; c <= col + hw; c++)
               if (r >= 0 && c >= 0 && r < eff_h && c < eff_w && !px_written[r * MAX_WIDTH + c])
                  send_pixel(r, c, pick_sample());
      end
      send_item(OP_COMPUTE, POS_W'(row), POS_W'(col), pick_sample());
   endtask

   task automatic wait_idle();
      if (req_valid) req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_config(int w, int h, int kw, int kh);
      wait_idle();
      csr_put(REG_UNUSED_LO + CSR_IDX_W'($urandom_range(0, 3)), CSR_DATA_W'($urandom));
      csr_put(REG_IMAGE_WIDTH, CSR_DATA_W'(w));
      csr_put(REG_IMAGE_HEIGHT, CSR_DATA_W'(h));
      csr_put(REG_KERNEL_WIDTH, {4'($urandom_range(0, 15)), KDIM_W'(kw)});
      csr_put(REG_KERNEL_HEIGHT, {4'($urandom_range(0, 15)), KDIM_W'(kh)});
      csr_valid <= 1'b0;
      eff_w = (w < MAX_WIDTH) ? w : MAX_WIDTH;
      eff_h = (h < MAX_HEIGHT) ? h : MAX_HEIGHT;
      span_w = kw % 8;
      span_h = kh % 8;
   endtask

   task automatic run_phase(int count);
      int stop_at, kind, row, col;
      stop_at = item_count + count;
      while (item_count < stop_at) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            row = (eff_h > 0) ? $urandom_range(0, eff_h - 1) : $urandom_range(0, 63);
            col = (eff_w > 0) ? $urandom_range(0, eff_w - 1) : $urandom_range(0, 63);
            send_compute(row, col);
         end else if (kind < 48) begin
            send_compute($urandom_range(0, 63), $urandom_range(0, 63));
         end else if (kind < 73) begin
            row = (eff_h > 0) ? $urandom_range(0, eff_h - 1) : $urandom_range(0, 63);
            col = (eff_w > 0) ? $urandom_range(0, eff_w - 1) : $urandom_range(0, 63);
            send_pixel(row, col, pick_sample());
         end else if (kind < 83) begin
            send_pixel($urandom_range(0, 63), $urandom_range(0, 63), pick_sample());
         end else if (kind < 95) begin
            if ($urandom_range(0, 3) == 0)
               send_coeff($urandom_range(0, 63), $urandom_range(0, 63), pick_sample());
            else
               send_coeff($urandom_range(0, MAX_KERNEL - 1), $urandom_range(0, MAX_KERNEL - 1),
                          pick_sample());
         end else begin
            send_item(OP_UNUSED, POS_W'($urandom), POS_W'($urandom), pick_sample());
         end
      end
   endtask

   function automatic int pick_image_size();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return $urandom_range(64, 127);
         default: return $urandom_range(1, 20);
      endcase
   endfunction

   function automatic int pick_kernel_size();
      if ($urandom_range(0, 5) == 0) return $urandom_range(0, 7);
      return 2 * $urandom_range(0, 3) + 1;
   endfunction

   initial begin
      int i, j;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 3; i++)
         for (j = 0; j < 3; j++)
            send_coeff(i, j, 16'sh8000);
      send_pixel(0, 0, 16'sh8000);
      send_pixel(0, 1, 16'sh8000);
      send_pixel(1, 0, 16'sh8000);
      send_pixel(1, 1, 16'sh8000);
      send_compute(0, 0);
      send_coeff(0, 7, 16'sh0000);
      send_coeff(7, 0, 16'sh7FFF);
      send_compute(0, 0);
      send_pixel(62, 62, 16'sh7FFF);
      send_pixel(62, 63, 16'sh7FFF);
      send_pixel(63, 62, 16'sh7FFF);
      send_pixel(63, 63, 16'sh7FFF);
      send_compute(63, 63);
      send_item(OP_UNUSED, 6'h3F, 6'h3F, 16'shFFFF);

      set_config(64, 64, 2, 3);
      send_compute(5, 5);
      set_config(64, 64, 3, 0);
      send_compute(63, 0);
      set_config(0, 64, 3, 3);
      send_compute(0, 0);
      set_config(127, 127, 3, 3);
      send_compute(63, 63);
      send_compute(0, 0);
      set_config(1, 1, 7, 7);
      send_compute(0, 0);
      set_config(64, 1, 1, 7);
      send_compute(0, 63);
      send_compute(1, 0);

      set_config(64, 64, 3, 3);
      run_phase(PHASE_ITEMS);
      set_config(1, 1, 1, 1);
      run_phase(PHASE_ITEMS);
      set_config(64, 64, 7, 7);
      run_phase(PHASE_ITEMS);
      set_config(9, 5, 5, 3);
      run_phase(PHASE_ITEMS);
      set_config(127, 90, 1, 7);
      run_phase(PHASE_ITEMS);
      set_config(16, 16, 3, 3);
      hold_requests++;
      run_phase(PHASE_ITEMS);
      for (i = 0; i < 5; i++) begin
         set_config(pick_image_size(), pick_image_size(), pick_kernel_size(), pick_kernel_size());
         run_phase(PHASE_ITEMS);
      end

      wait_idle();
      if (sb.failures == 0 && sb.pending() == 0)
         $display("PASS conv2d_same_zero_pad_unit");
      else
         $display("FAIL conv2d_same_zero_pad_unit");
      $finish;
   end

endmodule
